/* rtl/ookrc_pkg.sv */
// ----------------------------------------------------------------------------
// ookrc_pkg
// Shared constants and types for the OOK relative-change bit slicer.
// ----------------------------------------------------------------------------
package ookrc_pkg;

    localparam int MAG_W       = 24;   // band magnitude / previous level
    localparam int SUM_W       = 27;   // calibration sum
    localparam int CNT_W       = 3;    // calibration count
    localparam int RISE_W      = 8;
    localparam int FALL_W      = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CNT_W-1:0] CALIB_FRAMES = 3'd5;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RISE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALL = 1'd1;

    localparam logic [RISE_W-1:0] RISE_RESET = 8'd50;
    localparam logic [FALL_W-1:0] FALL_RESET = 7'd50;

    // Mean by reciprocal multiplication: sum * ceil(2^MEAN_SHIFT / CALIB_FRAMES)
    // gives the exact truncated quotient for any 27-bit sum and frame counts up to 7
    localparam int MEAN_SHIFT   = 30;
    localparam int MEAN_RECIP_W = 31;
    localparam int MEAN_PROD_W  = SUM_W + MEAN_RECIP_W;
    localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP = MEAN_RECIP_W'(
        ((64'd1 << MEAN_SHIFT) + 64'(CALIB_FRAMES) - 64'd1) / 64'(CALIB_FRAMES));

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* rtl/ookrc_mean_div.sv */
// ----------------------------------------------------------------------------
// ookrc_mean_div
// Divides the calibration sum by the frame count with a reciprocal multiply;
// the dividend is registered on start, then the product is registered as the quotient with done.
// ----------------------------------------------------------------------------
module ookrc_mean_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ookrc_pkg::SUM_W-1:0] i_dividend,
    output ookrc_pkg::t_div_rsp         o_rsp
);
    import ookrc_pkg::*;

    logic                   r_load;
    logic                   r_done;
    logic [SUM_W-1:0]       r_dvd;
    logic [MAG_W-1:0]       r_quo;
    logic [MEAN_PROD_W-1:0] w_prod;

    assign w_prod = MEAN_PROD_W'(r_dvd) * MEAN_PROD_W'(MEAN_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_load <= i_start;
            r_done <= r_load;
        end
    end

    // mean is kept to the level width
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
        end
        if (r_load) begin
            r_quo <= w_prod[MEAN_SHIFT +: MAG_W];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* rtl/ookrc_decide.sv */
// ----------------------------------------------------------------------------
// ookrc_decide
// Hysteresis decision from the cross-multiplied relative change.
// ----------------------------------------------------------------------------
module ookrc_decide (
    input  logic [ookrc_pkg::MAG_W-1:0]  i_mag,
    input  logic [ookrc_pkg::MAG_W-1:0]  i_prev,
    input  logic [ookrc_pkg::RISE_W-1:0] i_rise,
    input  logic [ookrc_pkg::FALL_W-1:0] i_fall,
    input  logic                         i_dec,
    output logic                         o_dec
);
    import ookrc_pkg::*;

    localparam int PROD_W = MAG_W + 9;

    logic [MAG_W+6:0]         w_mag100;
    logic signed [7:0]        w_kfall;
    logic [8:0]               w_krise;
    logic signed [PROD_W-1:0] w_fall_rhs;
    logic [PROD_W-1:0]        w_rise_rhs;
    logic                     w_fall;
    logic                     w_rise;

    // 100*(mag-prev) <= -fall*prev  <=>  100*mag <= (100-fall)*prev
    // 100*(mag-prev) >=  rise*prev  <=>  100*mag >= (100+rise)*prev
    assign w_mag100   = (MAG_W+7)'(i_mag) * (MAG_W+7)'(100);
    assign w_kfall    = 8'sd100 - $signed({1'b0, i_fall});
    assign w_krise    = 9'(i_rise) + 9'd100;
    assign w_fall_rhs = PROD_W'(w_kfall * $signed({1'b0, i_prev}));
    assign w_rise_rhs = PROD_W'(w_krise) * PROD_W'(i_prev);

    always_comb begin
        if (i_prev == '0) begin
            // no change when there is no previous level
            w_fall = (i_fall == '0);
            w_rise = (i_rise == '0);
        end else begin
            w_fall = $signed({2'b00, w_mag100}) <= w_fall_rhs;
            w_rise = {2'b00, w_mag100} >= w_rise_rhs;
        end
    end

    assign o_dec = i_dec ? !w_fall : w_rise;

endmodule

/* rtl/ook_relative_change_bit_slicer_top.sv */
// ----------------------------------------------------------------------------
// ook_relative_change_bit_slicer_top
// Calibrates a reference level, then slices pairs of band magnitudes into bits.
// ----------------------------------------------------------------------------
// Datapath: input register, then the decision into the result register.
// Throughput: one frame per cycle unless the result register stalls; after the last
//   calibration frame the next waits for the mean (operand register, then product).
// Reset: synchronous active low; clears state, restores rise/fall to 50.
// ----------------------------------------------------------------------------
module ook_relative_change_bit_slicer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ookrc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ookrc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [ookrc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // [23:0] band_magnitude
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [ookrc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata   // [0] received_bit
);
    import ookrc_pkg::*;

    logic [RISE_W-1:0] r_rise;
    logic [FALL_W-1:0] r_fall;

    logic              r_in_valid;
    logic [MAG_W-1:0]  r_in_mag;

    logic [MAG_W-1:0]  r_prev;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_dec;
    logic              r_phase;
    logic              r_first;
    logic              r_div_busy;

    logic              r_out_valid;
    logic              r_out_bit;

    logic              w_calib;
    logic              w_out_free;
    logic              w_fire;
    logic              w_start;
    logic [SUM_W-1:0]  n_sum;
    logic [CNT_W-1:0]  n_cnt;
    logic              w_slice;
    t_div_rsp          w_div_rsp;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise <= RISE_RESET;
            r_fall <= FALL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RISE: r_rise <= i_cfg_data[RISE_W-1:0];
                REG_FALL: r_fall <= i_cfg_data[FALL_W-1:0];
            endcase
        end
    end

    assign w_calib    = r_cnt < CALIB_FRAMES;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_fire     = r_in_valid && !r_div_busy && (w_calib || !r_phase || w_out_free);
    assign n_sum      = r_sum + SUM_W'(r_in_mag);
    assign n_cnt      = r_cnt + 1'b1;
    assign w_start    = w_fire && w_calib && (n_cnt == CALIB_FRAMES);

    assign o_s_axis_tready = !r_in_valid || w_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_mag <= i_s_axis_tdata[MAG_W-1:0];
        end
    end

    ookrc_mean_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (n_sum),
        .o_rsp      (w_div_rsp)
    );

    ookrc_decide u_decide (
        .i_mag  (r_in_mag),
        .i_prev (r_prev),
        .i_rise (r_rise),
        .i_fall (r_fall),
        .i_dec  (r_dec),
        .o_dec  (w_slice)
    );

    // slicer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_sum      <= '0;
            r_cnt      <= '0;
            r_dec      <= 1'b0;
            r_phase    <= 1'b0;
            r_first    <= 1'b0;
            r_div_busy <= 1'b0;
        end else begin
            if (w_div_rsp.done) begin
                r_prev     <= w_div_rsp.quotient;
                r_div_busy <= 1'b0;
            end
            if (w_fire) begin
                if (w_calib) begin
                    r_sum <= n_sum;
                    r_cnt <= n_cnt;
                    if (w_start) begin
                        r_div_busy <= 1'b1;
                    end
                end else begin
                    r_prev <= r_in_mag;
                    if (!r_phase) begin
                        r_dec   <= w_slice;
                        r_first <= w_slice;
                        r_phase <= 1'b1;
                    end else begin
                        // a zero first half forces the pair to zero
                        r_dec   <= w_slice && r_first;
                        r_first <= 1'b0;
                        r_phase <= 1'b0;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && !w_calib && r_phase) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && !w_calib && r_phase) begin
            r_out_bit <= w_slice && r_first;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_bit);

endmodule
